>>> hdl/expert_bucket_plan_builder_core_assert.svh
// Assertion macros for the expert bucket plan builder.
`ifndef EXPERT_BUCKET_PLAN_BUILDER_CORE_ASSERT_SVH
`define EXPERT_BUCKET_PLAN_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define EBPB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define EBPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ebpb_pkg.sv
// Package: constants, codes and types of the expert bucket plan builder.
package ebpb_pkg;

    localparam int MAX_EXPERTS  = 1024;
    localparam int EXP_AW       = $clog2(MAX_EXPERTS);
    localparam int REGION_PAD   = 256;
    localparam int ROW_CAPACITY = 65536;
    localparam int ROW_AW       = $clog2(ROW_CAPACITY);
    localparam int CNT_W        = 27;
    localparam int ROW_W        = 23;
    localparam int CFG_DW       = 17;
    localparam int CFG_AW       = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CNT_W:0]   PAD_ADD   = (CNT_W+1)'(REGION_PAD - 1);
    localparam logic [CNT_W:0]   PAD_MASK  = ~((CNT_W+1)'(REGION_PAD - 1));

    typedef enum logic [2:0] {
        CMD_CLEAR     = 3'd0,
        CMD_COUNT     = 3'd1,
        CMD_SCAN      = 3'd2,
        CMD_PLACE     = 3'd3,
        CMD_READ_BASE = 3'd4,
        CMD_READ_ROW  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_LOCAL_RANK  = 3'd0,
        CFG_EXPERTS     = 3'd1,
        CFG_TOKENS      = 3'd2,
        CFG_TOPK        = 3'd3,
        CFG_RANKS       = 3'd4,
        CFG_CAPACITY    = 3'd5
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_WR,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic        placed;
        logic        dropped;
        logic [15:0] packed_row;
        logic [5:0]  source_rank;
        logic [15:0] source_token;
        logic        row_valid;
        logic [31:0] value;
    } t_result;

endpackage

>>> hdl/ebpb_ifs.sv
// Request and result channel interfaces.
interface ebpb_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [15:0] expert_id;
    logic [15:0] index;

    modport source (output valid, command, expert_id, index, input ready);
    modport sink (input valid, command, expert_id, index, output ready);
endinterface

interface ebpb_rsp_if;
    logic        valid;
    logic        ready;
    logic        placed;
    logic        dropped;
    logic [15:0] packed_row;
    logic [5:0]  source_rank;
    logic [15:0] source_token;
    logic        row_valid;
    logic [31:0] value;

    modport source (output valid, placed, dropped, packed_row, source_rank, source_token,
                    row_valid, value, input ready);
    modport sink (input valid, placed, dropped, packed_row, source_rank, source_token,
                  row_valid, value, output ready);
endinterface

>>> hdl/expert_bucket_plan_builder_core.sv
// Expert bucket plan builder: histogram, padded prefix scan and slot placement.
//
// Requests arrive on i_req (command, expert_id, index); each gives exactly one
// result on o_rsp. Both channels move an item when valid and ready are high.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// One request is worked at a time; i_req.ready is high only in the idle state.
// Count, place and read requests pass through the execute and response states
// (accept with the memory read, update or write back, result load); the next
// request is taken once the block is back in the idle state.
// A scan walks the histogram memory, reading each window expert's count, then
// writing its base and next slot. A clear walks the row map, one row per cycle.
// After reset the same row map sweep runs with ready low and no result;
// configuration writes are taken during it.
// The result sits in an output register; the block takes the next request
// while it waits, and holds the following result until the receiver takes it.
// Throughput is bounded by the read-modify-write of the state memories.
module expert_bucket_plan_builder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ebpb_req_if.sink                      i_req,
    ebpb_rsp_if.source                    o_rsp,
    input  logic                          i_cfg_we,
    input  logic [ebpb_pkg::CFG_AW-1:0]   i_cfg_idx,
    input  logic [ebpb_pkg::CFG_DW-1:0]   i_cfg_data
);

    localparam int EAW = ebpb_pkg::EXP_AW;
    localparam int RAW = ebpb_pkg::ROW_AW;

    // configuration
    logic [5:0]  r_local_rank;
    logic [10:0] r_epr;
    logic [16:0] r_tpr;
    logic [4:0]  r_topk;
    logic [6:0]  r_ranks;
    logic [16:0] r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_rank <= 6'd0;
            r_epr        <= 11'd32;
            r_tpr        <= 17'd1024;
            r_topk       <= 5'd8;
            r_ranks      <= 7'd8;
            r_cap        <= 17'd65536;
        end else if (i_cfg_we) begin
            case (ebpb_pkg::t_cfg_reg'(i_cfg_idx))
                ebpb_pkg::CFG_LOCAL_RANK: r_local_rank <= i_cfg_data[5:0];
                ebpb_pkg::CFG_EXPERTS:    r_epr        <= i_cfg_data[10:0];
                ebpb_pkg::CFG_TOKENS:     r_tpr        <= i_cfg_data;
                ebpb_pkg::CFG_TOPK:       r_topk       <= i_cfg_data[4:0];
                ebpb_pkg::CFG_RANKS:      r_ranks      <= i_cfg_data[6:0];
                ebpb_pkg::CFG_CAPACITY:   r_cap        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memories
    logic [ebpb_pkg::CNT_W-1:0] cnt_mem [ebpb_pkg::MAX_EXPERTS];
    logic [31:0]                base_mem [ebpb_pkg::MAX_EXPERTS];
    logic [31:0]                ns_mem [ebpb_pkg::MAX_EXPERTS];
    logic [ebpb_pkg::ROW_W-1:0] row_mem [ebpb_pkg::ROW_CAPACITY];

    logic                       cnt_we, cnt_re, base_we, base_re, ns_we, ns_re;
    logic                       row_we, row_re;
    logic [EAW-1:0]             cnt_wa, cnt_ra, base_wa, base_ra, ns_wa, ns_ra;
    logic [RAW-1:0]             row_wa, row_ra;
    logic [ebpb_pkg::CNT_W-1:0] cnt_wd, r_cnt_q;
    logic [31:0]                base_wd, ns_wd, r_base_q, r_ns_q;
    logic [ebpb_pkg::ROW_W-1:0] row_wd, r_row_q;

    always_ff @(posedge i_clk) begin
        if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
        if (cnt_re) r_cnt_q <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (base_we) base_mem[base_wa] <= base_wd;
        if (base_re) r_base_q <= base_mem[base_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ns_we) ns_mem[ns_wa] <= ns_wd;
        if (ns_re) r_ns_q <= ns_mem[ns_ra];
    end

    always_ff @(posedge i_clk) begin
        if (row_we) row_mem[row_wa] <= row_wd;
        if (row_re) r_row_q <= row_mem[row_ra];
    end

    // control state
    ebpb_pkg::t_state  r_state, n_state;
    ebpb_pkg::t_cmd    r_cmd, n_cmd;
    logic              r_local, n_local;
    logic [EAW-1:0]    r_off, n_off;
    logic [1:0]        r_rb_sel, n_rb_sel;   // read base: 1 base, 2 total, 0 zero
    logic [RAW-1:0]    r_sw, n_sw;
    logic              r_sw_rsp, n_sw_rsp;
    logic [10:0]       r_e, n_e;
    logic [31:0]       r_acc, n_acc;
    logic [31:0]       r_total, n_total;
    logic [3:0]        r_sc, n_sc;
    logic [15:0]       r_tc, n_tc;
    logic [5:0]        r_rc, n_rc;
    ebpb_pkg::t_result r_pend, n_pend;
    ebpb_pkg::t_result r_out, n_out;
    logic              r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ebpb_pkg::ST_SWEEP;
            r_sw     <= '0;
            r_sw_rsp <= 1'b0;
            r_total  <= '0;
            r_sc     <= '0;
            r_tc     <= '0;
            r_rc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sw     <= n_sw;
            r_sw_rsp <= n_sw_rsp;
            r_total  <= n_total;
            r_sc     <= n_sc;
            r_tc     <= n_tc;
            r_rc     <= n_rc;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_local  <= n_local;
        r_off    <= n_off;
        r_rb_sel <= n_rb_sel;
        r_e      <= n_e;
        r_acc    <= n_acc;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    // window decode of the incoming id
    logic [16:0] win_lo, win_diff;
    logic [10:0] eff;
    logic        in_local;

    assign win_lo   = 17'(r_local_rank * r_epr);
    assign win_diff = {1'b0, i_req.expert_id} - win_lo;
    assign eff      = (r_epr > 11'(ebpb_pkg::MAX_EXPERTS)) ? 11'(ebpb_pkg::MAX_EXPERTS) : r_epr;
    assign in_local = ({1'b0, i_req.expert_id} >= win_lo) && (win_diff < {6'd0, eff});

    logic        accept, out_free;
    logic [16:0] cap_eff;
    logic [ebpb_pkg::CNT_W:0] cnt_pad;
    logic [32:0] acc_sum;
    logic [31:0] acc_sat;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_ovalid || o_rsp.ready;
    assign cap_eff  = (r_cap > 17'(ebpb_pkg::ROW_CAPACITY)) ? 17'(ebpb_pkg::ROW_CAPACITY) : r_cap;
    assign cnt_pad  = ({1'b0, r_cnt_q} + ebpb_pkg::PAD_ADD) & ebpb_pkg::PAD_MASK;
    assign acc_sum  = {1'b0, r_acc} + 33'(cnt_pad);
    assign acc_sat  = acc_sum[32] ? '1 : acc_sum[31:0];

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_local  = r_local;
        n_off    = r_off;
        n_rb_sel = r_rb_sel;
        n_sw     = r_sw;
        n_sw_rsp = r_sw_rsp;
        n_e      = r_e;
        n_acc    = r_acc;
        n_total  = r_total;
        n_sc     = r_sc;
        n_tc     = r_tc;
        n_rc     = r_rc;
        n_pend   = r_pend;
        n_out    = r_out;
        n_ovalid = r_ovalid;

        i_req.ready = 1'b0;
        cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0;
        cnt_re = 1'b0; cnt_ra = '0;
        base_we = 1'b0; base_wa = '0; base_wd = '0;
        base_re = 1'b0; base_ra = '0;
        ns_we = 1'b0; ns_wa = '0; ns_wd = '0;
        ns_re = 1'b0; ns_ra = '0;
        row_we = 1'b0; row_wa = '0; row_wd = '0;
        row_re = 1'b0; row_ra = '0;

        // drain the output register independently of the state
        if (r_ovalid && o_rsp.ready) n_ovalid = 1'b0;

        case (r_state)
            ebpb_pkg::ST_SWEEP: begin
                row_we = 1'b1;
                row_wa = r_sw;
                cnt_wa = r_sw[EAW-1:0];
                cnt_we = (r_sw[RAW-1:EAW] == '0);
                n_sw   = r_sw + 1'b1;
                if (r_sw == '1) begin
                    n_pend = '0;
                    n_state = r_sw_rsp ? ebpb_pkg::ST_RESP : ebpb_pkg::ST_IDLE;
                end
            end
            ebpb_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (accept) begin
                    n_cmd   = ebpb_pkg::t_cmd'(i_req.command);
                    n_local = in_local;
                    n_off   = win_diff[EAW-1:0];
                    n_pend  = '0;
                    n_state = ebpb_pkg::ST_EXEC;
                    cnt_ra  = win_diff[EAW-1:0];
                    ns_ra   = win_diff[EAW-1:0];
                    base_ra = i_req.index[EAW-1:0];
                    row_ra  = i_req.index[RAW-1:0];
                    if ({5'd0, eff} > i_req.index) n_rb_sel = 2'd1;
                    else if ({5'd0, eff} == i_req.index) n_rb_sel = 2'd2;
                    else n_rb_sel = 2'd0;
                    case (ebpb_pkg::t_cmd'(i_req.command))
                        ebpb_pkg::CMD_CLEAR: begin
                            n_sc = '0; n_tc = '0; n_rc = '0;
                            n_sw = '0;
                            n_sw_rsp = 1'b1;
                            n_state = ebpb_pkg::ST_SWEEP;
                        end
                        ebpb_pkg::CMD_COUNT:     cnt_re  = in_local;
                        ebpb_pkg::CMD_PLACE:     ns_re   = in_local;
                        ebpb_pkg::CMD_READ_BASE: base_re = ({5'd0, eff} > i_req.index);
                        ebpb_pkg::CMD_READ_ROW:  row_re  = 1'b1;
                        ebpb_pkg::CMD_SCAN: begin
                            if (r_epr > 11'(ebpb_pkg::MAX_EXPERTS)) begin
                                n_pend.value = '1;
                                n_state = ebpb_pkg::ST_RESP;
                            end else if (r_epr == '0) begin
                                n_total = '0;
                                n_sc = '0; n_tc = '0; n_rc = '0;
                                n_state = ebpb_pkg::ST_RESP;
                            end else begin
                                n_e = '0;
                                n_acc = '0;
                                n_state = ebpb_pkg::ST_SCAN_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ebpb_pkg::ST_EXEC: begin
                n_state = ebpb_pkg::ST_RESP;
                case (r_cmd)
                    ebpb_pkg::CMD_COUNT: begin
                        cnt_wa = r_off;
                        cnt_wd = r_cnt_q + 1'b1;
                        cnt_we = r_local && (r_cnt_q != ebpb_pkg::COUNT_MAX);
                    end
                    ebpb_pkg::CMD_PLACE: begin
                        // advance position counters for every place request
                        if ({1'b0, r_sc} + 5'd1 < r_topk && r_sc != 4'hF) begin
                            n_sc = r_sc + 1'b1;
                        end else begin
                            n_sc = '0;
                            if ({1'b0, r_tc} + 17'd1 < r_tpr && r_tc != 16'hFFFF) begin
                                n_tc = r_tc + 1'b1;
                            end else begin
                                n_tc = '0;
                                if ({1'b0, r_rc} + 7'd1 < r_ranks && r_rc != 6'h3F)
                                    n_rc = r_rc + 1'b1;
                                else
                                    n_rc = '0;
                            end
                        end
                        if (r_local) begin
                            ns_wa = r_off;
                            ns_wd = r_ns_q + 1'b1;
                            ns_we = (r_ns_q != '1);
                            n_pend.source_rank  = r_rc;
                            n_pend.source_token = r_tc;
                            if (r_ns_q < {15'd0, cap_eff}) begin
                                row_we = 1'b1;
                                row_wa = r_ns_q[RAW-1:0];
                                row_wd = {1'b1, r_rc, r_tc};
                                n_pend.placed     = 1'b1;
                                n_pend.packed_row = r_ns_q[15:0];
                            end else begin
                                n_pend.dropped = 1'b1;
                            end
                        end
                    end
                    ebpb_pkg::CMD_READ_BASE: begin
                        case (r_rb_sel)
                            2'd1:    n_pend.value = r_base_q;
                            2'd2:    n_pend.value = r_total;
                            default: n_pend.value = '0;
                        endcase
                    end
                    ebpb_pkg::CMD_READ_ROW: begin
                        if (r_row_q[ebpb_pkg::ROW_W-1]) begin
                            n_pend.row_valid    = 1'b1;
                            n_pend.source_rank  = r_row_q[21:16];
                            n_pend.source_token = r_row_q[15:0];
                        end
                    end
                    default: ;
                endcase
            end
            ebpb_pkg::ST_SCAN_RD: begin
                cnt_re  = 1'b1;
                cnt_ra  = r_e[EAW-1:0];
                n_state = ebpb_pkg::ST_SCAN_WR;
            end
            ebpb_pkg::ST_SCAN_WR: begin
                base_we = 1'b1;
                base_wa = r_e[EAW-1:0];
                base_wd = r_acc;
                ns_we   = 1'b1;
                ns_wa   = r_e[EAW-1:0];
                ns_wd   = r_acc;
                n_acc   = acc_sat;
                n_e     = r_e + 1'b1;
                if (r_e + 11'd1 == r_epr) begin
                    n_total = acc_sat;
                    n_sc = '0; n_tc = '0; n_rc = '0;
                    n_pend.value = acc_sat;
                    n_state = ebpb_pkg::ST_RESP;
                end else begin
                    n_state = ebpb_pkg::ST_SCAN_RD;
                end
            end
            ebpb_pkg::ST_RESP: begin
                if (out_free) begin
                    n_out    = r_pend;
                    n_ovalid = 1'b1;
                    n_state  = ebpb_pkg::ST_IDLE;
                end
            end
            default: n_state = ebpb_pkg::ST_IDLE;
        endcase
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.placed       = r_out.placed;
    assign o_rsp.dropped      = r_out.dropped;
    assign o_rsp.packed_row   = r_out.packed_row;
    assign o_rsp.source_rank  = r_out.source_rank;
    assign o_rsp.source_token = r_out.source_token;
    assign o_rsp.row_valid    = r_out.row_valid;
    assign o_rsp.value        = r_out.value;

`include "expert_bucket_plan_builder_core_assert.svh"

    `EBPB_ASSERT_NEXT(a_one_at_a_time, accept, !i_req.ready, "request accepted while busy")
    `EBPB_ASSERT_NOW(a_place_or_drop, r_ovalid, !(r_out.placed && r_out.dropped),
                     "result both placed and dropped")
    `EBPB_ASSERT_NOW(a_row_in_cap, row_we && (r_state == ebpb_pkg::ST_EXEC),
                     {1'b0, row_wa} < cap_eff, "row written beyond capacity")

endmodule

>>> sim/tb.sv
// Testbench of the expert bucket plan builder: self-checking, random handshakes.
`timescale 1ns / 100ps

module tb;

    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;
    localparam int         IDLE_LIMIT = 400000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [ebpb_pkg::CFG_AW-1:0]   i_cfg_idx;
    logic [ebpb_pkg::CFG_DW-1:0]   i_cfg_data;

    ebpb_req_if req_ch ();
    ebpb_rsp_if rsp_ch ();

    expert_bucket_plan_builder_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Plan state as the block should hold it
    int unsigned  reg_rank, reg_experts, reg_tokens, reg_topk, reg_ranks, reg_capacity;
    logic [26:0]  hist [ebpb_pkg::MAX_EXPERTS];
    logic [31:0]  region_base [ebpb_pkg::MAX_EXPERTS];
    logic [31:0]  region_next [ebpb_pkg::MAX_EXPERTS];
    logic [22:0]  plan_rows [ebpb_pkg::ROW_CAPACITY];
    logic [31:0]  padded_total;
    int unsigned  pos_slot, pos_token, pos_rank;

    ebpb_pkg::t_result pending_results[$];
    int           mismatches = 0;
    int           hold_cycles;
    bit           steady;
    int           quiet_cycles = 0;
    int           clears_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned window_size();
        return (reg_experts > ebpb_pkg::MAX_EXPERTS) ? ebpb_pkg::MAX_EXPERTS : reg_experts;
    endfunction

    function automatic bit window_offset(input int unsigned id, output int unsigned off);
        int unsigned lo;
        lo = reg_rank * reg_experts;
        off = 0;
        if (id < lo || id - lo >= window_size()) return 1'b0;
        off = id - lo;
        return 1'b1;
    endfunction

    function automatic void advance_position();
        if (pos_slot + 1 < reg_topk && pos_slot < 15) begin
            pos_slot++;
            return;
        end
        pos_slot = 0;
        if (pos_token + 1 < reg_tokens && pos_token < 65535) begin
            pos_token++;
            return;
        end
        pos_token = 0;
        if (pos_rank + 1 < reg_ranks && pos_rank < 63) pos_rank++;
        else pos_rank = 0;
    endfunction

    function automatic ebpb_pkg::t_result plan_step(input logic [2:0] cmd,
                                                    input logic [15:0] id,
                                                    input logic [15:0] idx);
        ebpb_pkg::t_result r;
        int unsigned off, cap, rk, tk;
        longint unsigned acc;
        logic [31:0] slot;
        r = '0;
        case (cmd)
            ebpb_pkg::CMD_CLEAR: begin
                foreach (hist[e]) hist[e] = '0;
                foreach (plan_rows[i]) plan_rows[i] = '0;
                pos_slot = 0; pos_token = 0; pos_rank = 0;
            end
            ebpb_pkg::CMD_COUNT: begin
                if (window_offset(id, off) && hist[off] != ebpb_pkg::COUNT_MAX) hist[off]++;
            end
            ebpb_pkg::CMD_SCAN: begin
                if (reg_experts > ebpb_pkg::MAX_EXPERTS) begin
                    r.value = 32'hFFFF_FFFF;
                end else begin
                    acc = 0;
                    for (int e = 0; e < reg_experts; e++) begin
                        region_base[e] = acc[31:0];
                        region_next[e] = acc[31:0];
                        acc += ((longint'(hist[e]) + ebpb_pkg::REGION_PAD - 1)
                                / ebpb_pkg::REGION_PAD) * ebpb_pkg::REGION_PAD;
                        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
                    end
                    padded_total = acc[31:0];
                    pos_slot = 0; pos_token = 0; pos_rank = 0;
                    r.value = padded_total;
                end
            end
            ebpb_pkg::CMD_PLACE: begin
                rk = pos_rank;
                tk = pos_token;
                advance_position();
                if (window_offset(id, off)) begin
                    slot = region_next[off];
                    cap = (reg_capacity > ebpb_pkg::ROW_CAPACITY) ? ebpb_pkg::ROW_CAPACITY
                                                                  : reg_capacity;
                    if (slot != 32'hFFFF_FFFF) region_next[off] = slot + 1;
                    r.source_rank  = rk[5:0];
                    r.source_token = tk[15:0];
                    if (slot < cap) begin
                        plan_rows[slot[15:0]] = {1'b1, rk[5:0], tk[15:0]};
                        r.placed     = 1'b1;
                        r.packed_row = slot[15:0];
                    end else begin
                        r.dropped = 1'b1;
                    end
                end
            end
            ebpb_pkg::CMD_READ_BASE: begin
                if (idx < window_size()) r.value = region_base[idx];
                else if (idx == window_size()) r.value = padded_total;
            end
            ebpb_pkg::CMD_READ_ROW: begin
                if (plan_rows[idx][22]) begin
                    r.row_valid    = 1'b1;
                    r.source_rank  = plan_rows[idx][21:16];
                    r.source_token = plan_rows[idx][15:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        if (steady) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one request; leave valid high so back-to-back requests need no lowering
    task automatic send_request(input logic [2:0] cmd, input logic [15:0] id,
                                input logic [15:0] idx);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.command   = cmd;
        req_ch.expert_id = id;
        req_ch.index     = idx;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(plan_step(cmd, id, idx));
        @(negedge i_clk);
    endtask

    task automatic stop_requests();
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_idle();
        stop_requests();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input ebpb_pkg::t_cfg_reg ridx, input int unsigned data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = ridx;
        i_cfg_data = data[ebpb_pkg::CFG_DW-1:0];
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (ridx)
            ebpb_pkg::CFG_LOCAL_RANK: reg_rank     = data & 32'h3F;
            ebpb_pkg::CFG_EXPERTS:    reg_experts  = data & 32'h7FF;
            ebpb_pkg::CFG_TOKENS:     reg_tokens   = data & 32'h1FFFF;
            ebpb_pkg::CFG_TOPK:       reg_topk     = data & 32'h1F;
            ebpb_pkg::CFG_RANKS:      reg_ranks    = data & 32'h7F;
            ebpb_pkg::CFG_CAPACITY:   reg_capacity = data & 32'h1FFFF;
            default: ;
        endcase
    endtask

    task automatic set_plan(input int unsigned rank, experts, tokens, topk, ranks, cap);
        write_reg(ebpb_pkg::CFG_LOCAL_RANK, rank);
        write_reg(ebpb_pkg::CFG_EXPERTS, experts);
        write_reg(ebpb_pkg::CFG_TOKENS, tokens);
        write_reg(ebpb_pkg::CFG_TOPK, topk);
        write_reg(ebpb_pkg::CFG_RANKS, ranks);
        write_reg(ebpb_pkg::CFG_CAPACITY, cap);
    endtask

    function automatic logic [15:0] pick_id();
        int unsigned lo, n;
        lo = reg_rank * reg_experts;
        n = window_size();
        if ($urandom_range(0, 9) < 8 && n > 0 && lo < 65536)
            return 16'(lo + $urandom_range(0, n < 6 ? n - 1 : 5));
        if ($urandom_range(0, 1) && lo < 65536)
            return 16'(lo + $urandom_range(0, n + 2));
        return 16'($urandom());
    endfunction

    // Write every base once so that later reads and places never see unwritten entries
    task automatic test_directed();
        set_plan(0, 1024, 4, 2, 3, 65536);
        send_request(ebpb_pkg::CMD_SCAN, '0, '0);
        send_request(ebpb_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF);
        send_request(ebpb_pkg::CMD_COUNT, 16'd0, '0);
        send_request(ebpb_pkg::CMD_COUNT, 16'd0, '0);
        send_request(ebpb_pkg::CMD_COUNT, 16'd1023, '0);
        send_request(ebpb_pkg::CMD_COUNT, 16'd1024, '0);
        send_request(ebpb_pkg::CMD_COUNT, 16'hFFFF, '0);
        send_request(ebpb_pkg::CMD_SCAN, '0, '0);
        send_request(ebpb_pkg::CMD_PLACE, 16'd0, '0);
        send_request(ebpb_pkg::CMD_PLACE, 16'd1023, '0);
        send_request(ebpb_pkg::CMD_PLACE, 16'hFFFF, '0);
        send_request(ebpb_pkg::CMD_PLACE, 16'd0, '0);
        send_request(ebpb_pkg::CMD_READ_BASE, '0, 16'd1);
        send_request(ebpb_pkg::CMD_READ_BASE, '0, 16'd1023);
        send_request(ebpb_pkg::CMD_READ_BASE, '0, 16'd1024);
        send_request(ebpb_pkg::CMD_READ_BASE, '0, 16'hFFFF);
        send_request(ebpb_pkg::CMD_READ_ROW, '0, 16'd0);
        send_request(ebpb_pkg::CMD_READ_ROW, '0, 16'd512);
        send_request(ebpb_pkg::CMD_READ_ROW, '0, 16'hFFFF);
        send_request(CMD_RSVD_6, 16'hFFFF, 16'hFFFF);
        send_request(CMD_RSVD_7, 16'h5A5A, 16'hA5A5);
        wait_idle();
    endtask

    task automatic test_corner_settings();
        // oversized window: scan writes nothing, counters keep running
        set_plan(1, 2047, 131071, 31, 127, 131071);
        send_request(ebpb_pkg::CMD_COUNT, 16'd1024, '0);
        send_request(ebpb_pkg::CMD_PLACE, 16'd1024, '0);
        send_request(ebpb_pkg::CMD_SCAN, '0, '0);
        send_request(ebpb_pkg::CMD_PLACE, 16'd2047, '0);
        send_request(ebpb_pkg::CMD_READ_BASE, '0, 16'd1024);
        wait_idle();
        // empty window and zero capacity
        set_plan(63, 0, 0, 0, 0, 0);
        send_request(ebpb_pkg::CMD_COUNT, 16'd0, '0);
        send_request(ebpb_pkg::CMD_SCAN, '0, '0);
        send_request(ebpb_pkg::CMD_PLACE, 16'd0, '0);
        send_request(ebpb_pkg::CMD_READ_BASE, '0, 16'd0);
        wait_idle();
        set_plan(2, 3, 1, 1, 1, 0);
        send_request(ebpb_pkg::CMD_COUNT, 16'd6, '0);
        send_request(ebpb_pkg::CMD_SCAN, '0, '0);
        repeat (3) send_request(ebpb_pkg::CMD_PLACE, 16'd6, '0);
        wait_idle();
        // counter wrap through slot, token and rank
        set_plan(0, 2, 2, 2, 2, 65536);
        send_request(ebpb_pkg::CMD_SCAN, '0, '0);
        repeat (10) send_request(ebpb_pkg::CMD_PLACE, 16'd1, '0);
        wait_idle();
    endtask

    task automatic test_random_plans(input int budget);
        logic [15:0] ids[$];
        int          done, n;
        done = 0;
        while (done < budget) begin
            case ($urandom_range(0, 9))
                0:       set_plan($urandom_range(0, 63), 1024, $urandom_range(1, 65536),
                                  $urandom_range(1, 16), $urandom_range(1, 64), 65536);
                1:       set_plan($urandom_range(0, 63), $urandom_range(1025, 2047),
                                  $urandom_range(0, 131071), $urandom_range(0, 31),
                                  $urandom_range(0, 127), $urandom_range(0, 131071));
                2:       set_plan($urandom_range(0, 63), $urandom_range(1, 8), 1, 1,
                                  $urandom_range(1, 4), $urandom_range(0, 600));
                default: set_plan($urandom_range(0, 63), $urandom_range(1, 64),
                                  $urandom_range(1, 5), $urandom_range(1, 16),
                                  $urandom_range(1, 64),
                                  $urandom_range(0, 1) ? 65536 : $urandom_range(1, 2000));
            endcase
            steady = ($urandom_range(0, 4) == 0);
            if (clears_left > 0 && $urandom_range(0, 14) == 0) begin
                clears_left--;
                send_request(ebpb_pkg::CMD_CLEAR, 16'($urandom()), 16'($urandom()));
                done++;
            end
            ids.delete();
            n = $urandom_range(4, 30);
            repeat (n) ids.push_back(pick_id());
            foreach (ids[i]) send_request(ebpb_pkg::CMD_COUNT, ids[i], 16'($urandom()));
            send_request(ebpb_pkg::CMD_SCAN, 16'($urandom()), 16'($urandom()));
            foreach (ids[i]) begin
                send_request(ebpb_pkg::CMD_PLACE, ids[i], 16'($urandom()));
                if ($urandom_range(0, 9) == 0)
                    send_request($urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7,
                                 16'($urandom()), 16'($urandom()));
            end
            repeat ($urandom_range(2, 8)) begin
                if ($urandom_range(0, 1))
                    send_request(ebpb_pkg::CMD_READ_BASE, 16'($urandom()),
                                 $urandom_range(0, 3) ? 16'($urandom_range(0, window_size() + 1))
                                                      : 16'($urandom()));
                else
                    send_request(ebpb_pkg::CMD_READ_ROW, 16'($urandom()),
                                 $urandom_range(0, 3) ? 16'($urandom_range(0, 2047))
                                                      : 16'($urandom()));
            end
            if ($urandom_range(0, 4) == 0)
                send_request(ebpb_pkg::CMD_PLACE, 16'($urandom()), 16'($urandom()));
            done += 2 * n + 6;
            wait_idle();
        end
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        set_plan(0, 16, 4, 4, 4, 65536);
        send_request(ebpb_pkg::CMD_SCAN, '0, '0);
        wait_idle();
        steady = 1'b1;
        hold_cycles = 300;
        repeat (20) send_request(ebpb_pkg::CMD_PLACE, 16'($urandom_range(0, 15)), '0);
        repeat (10) send_request(ebpb_pkg::CMD_READ_ROW, '0, 16'($urandom_range(0, 300)));
        steady = 1'b0;
        wait_idle();
    endtask

    // Receiver: random stalls, a forced hold-off, compare with the oldest prediction
    initial begin
        int stall;
        ebpb_pkg::t_result got, want;
        stall = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = {rsp_ch.placed, rsp_ch.dropped, rsp_ch.packed_row, rsp_ch.source_rank,
                       rsp_ch.source_token, rsp_ch.row_valid, rsp_ch.value};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p got %p", want, got);
                    end
                end
            end
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                rsp_ch.ready = 1'b0;
            end else if (stall > 0) begin
                stall--;
                rsp_ch.ready = 1'b0;
            end else if (steady) begin
                rsp_ch.ready = 1'b1;
            end else begin
                stall = gap_len();
                rsp_ch.ready = (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    // Stop on a run with no handshakes for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        req_ch.valid     = 1'b0;
        req_ch.command   = ebpb_pkg::CMD_CLEAR;
        req_ch.expert_id = '0;
        req_ch.index     = '0;
        hold_cycles      = 0;
        steady           = 1'b0;
        clears_left      = 2;
        reg_rank = 0; reg_experts = 32; reg_tokens = 1024;
        reg_topk = 8; reg_ranks = 8; reg_capacity = 65536;
        foreach (hist[e]) begin
            hist[e] = '0;
            region_base[e] = '0;
            region_next[e] = '0;
        end
        foreach (plan_rows[i]) plan_rows[i] = '0;
        padded_total = '0;
        pos_slot = 0; pos_token = 0; pos_rank = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_corner_settings();
        test_backpressure();
        test_random_plans(1400);
        test_backpressure();

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/ebpb_pkg.sv
hdl/ebpb_ifs.sv
hdl/expert_bucket_plan_builder_core.sv
sim/tb.sv
